>>> rtl/core/macp_pkg.sv
package macp_pkg;

    localparam int MAX_TEXT_LEN_DEF = 17;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_DASH  = 8'h2d;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;

    localparam logic [3:0] ALPHA_OFFSET = 4'd9;

    localparam logic [2:0] LAST_FIELD_SIX   = 3'd5;
    localparam logic [2:0] LAST_FIELD_THREE = 3'd2;
    localparam logic [2:0] MAX_DIGITS       = 3'd4;
    localparam logic [2:0] BYTE_DIGITS      = 3'd2;

    localparam logic [2:0] FMT_SIX_BASE   = 3'd0;
    localparam logic [2:0] FMT_THREE_BASE = 3'd3;
    localparam logic [2:0] FMT_INVALID    = 3'd0;

    typedef enum logic [1:0] {
        CLS_HEX,
        CLS_SEP,
        CLS_NUL,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_COLON,
        SEP_DASH,
        SEP_DOT
    } sep_kind_t;

    typedef struct packed {
        char_class_t cls;
        sep_kind_t   sep;
        logic [3:0]  nibble;
    } char_entry_t;

    typedef struct packed {
        logic        valid;
        char_entry_t entry;
    } queue_head_t;

endpackage

>>> rtl/core/macp_front.sv
module macp_front
    import macp_pkg::*;
(
    input  logic [7:0]  text_char,
    output char_entry_t entry
);

    always_comb
    begin
        entry.cls    = CLS_OTHER;
        entry.sep    = SEP_NONE;
        entry.nibble = text_char[3:0];
        if (text_char == CHAR_NUL)
        begin
            entry.cls = CLS_NUL;
        end
        else if (text_char inside {[8'h30:8'h39]})
        begin
            entry.cls = CLS_HEX;
        end
        else if (text_char inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            entry.cls    = CLS_HEX;
            entry.nibble = text_char[3:0] + ALPHA_OFFSET;
        end
        else if (text_char == CHAR_COLON)
        begin
            entry.cls = CLS_SEP;
            entry.sep = SEP_COLON;
        end
        else if (text_char == CHAR_DASH)
        begin
            entry.cls = CLS_SEP;
            entry.sep = SEP_DASH;
        end
        else if (text_char == CHAR_DOT)
        begin
            entry.cls = CLS_SEP;
            entry.sep = SEP_DOT;
        end
    end

endmodule

>>> rtl/core/macp_queue.sv
module macp_queue
    import macp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output queue_head_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    char_entry_t   slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/macp_back.sv
module macp_back
    import macp_pkg::*;
#(
    parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] mac_address,
    output logic        valid_res,
    output logic [2:0]  format
);

    localparam int CW = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_TEXT_LEN);

    sep_kind_t     sep_reg, sep_next;
    logic [2:0]    field_reg, field_next;
    logic [2:0]    digits_reg, digits_next;
    logic [15:0]   value_reg, value_next;
    logic [47:0]   six_reg, six_next;
    logic [47:0]   three_reg, three_next;
    logic [CW-1:0] chars_reg, chars_next;
    logic          bad_reg, bad_next;
    logic          wide_reg, wide_next;

    logic          out_valid_reg, out_valid_next;
    logic [47:0]   mac_reg, mac_next;
    logic          ok_reg, ok_next;
    logic [2:0]    fmt_reg, fmt_next;

    char_entry_t   entry;
    logic          take;
    logic          take_nul;
    logic          wide_last;
    logic [2:0]    sep_off;

    assign entry       = head.entry;
    assign take        = head.valid && (entry.cls != CLS_NUL || !out_valid_reg || out_ready);
    assign take_nul    = take && entry.cls == CLS_NUL;
    assign pop         = take;
    assign out_valid   = out_valid_reg;
    assign mac_address = mac_reg;
    assign valid_res   = ok_reg;
    assign format      = fmt_reg;
    assign wide_last   = wide_reg || digits_reg > BYTE_DIGITS;
    assign sep_off     = {1'b0, sep_reg} - 3'd1;

    always_comb
    begin
        sep_next       = sep_reg;
        field_next     = field_reg;
        digits_next    = digits_reg;
        value_next     = value_reg;
        six_next       = six_reg;
        three_next     = three_reg;
        chars_next     = chars_reg;
        bad_next       = bad_reg;
        wide_next      = wide_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mac_next       = mac_reg;
        ok_next        = ok_reg;
        fmt_next       = fmt_reg;

        if (take_nul)
        begin
            out_valid_next = 1'b1;
            mac_next       = '0;
            ok_next        = 1'b0;
            fmt_next       = FMT_INVALID;
            if (!bad_reg && digits_reg != '0 && sep_reg != SEP_NONE)
            begin
                if (field_reg == LAST_FIELD_SIX && !wide_last)
                begin
                    ok_next  = 1'b1;
                    mac_next = {six_reg[47:8], value_reg[7:0]};
                    fmt_next = FMT_SIX_BASE + sep_off;
                end
                else if (field_reg == LAST_FIELD_THREE)
                begin
                    ok_next  = 1'b1;
                    mac_next = {three_reg[47:16], value_reg};
                    fmt_next = FMT_THREE_BASE + sep_off;
                end
            end
            sep_next    = SEP_NONE;
            field_next  = '0;
            digits_next = '0;
            value_next  = '0;
            six_next    = '0;
            three_next  = '0;
            chars_next  = '0;
            bad_next    = 1'b0;
            wide_next   = 1'b0;
        end
        else if (take)
        begin
            if (chars_reg >= MAX_LEN)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                chars_next = chars_reg + CW'(1);
            end
            if (!bad_reg && chars_reg < MAX_LEN)
            begin
                case (entry.cls)
                    CLS_HEX:
                    begin
                        if (digits_reg >= MAX_DIGITS)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            value_next  = {value_reg[11:0], entry.nibble};
                            digits_next = digits_reg + 3'd1;
                        end
                    end
                    CLS_SEP:
                    begin
                        if (sep_reg == SEP_NONE)
                        begin
                            sep_next = entry.sep;
                        end
                        if (sep_reg != SEP_NONE && sep_reg != entry.sep)
                        begin
                            bad_next = 1'b1;
                        end
                        else if (digits_reg == '0 || field_reg >= LAST_FIELD_SIX)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            wide_next = wide_last;
                            for (int i = 0; i < 6; i++)
                            begin
                                if (field_reg == 3'(i))
                                begin
                                    six_next[47-8*i -: 8] = value_reg[7:0];
                                end
                            end
                            for (int i = 0; i < 3; i++)
                            begin
                                if (field_reg == 3'(i))
                                begin
                                    three_next[47-16*i -: 16] = value_reg;
                                end
                            end
                            field_next  = field_reg + 3'd1;
                            digits_next = '0;
                            value_next  = '0;
                        end
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg       <= SEP_NONE;
            field_reg     <= '0;
            digits_reg    <= '0;
            value_reg     <= '0;
            six_reg       <= '0;
            three_reg     <= '0;
            chars_reg     <= '0;
            bad_reg       <= 1'b0;
            wide_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sep_reg       <= sep_next;
            field_reg     <= field_next;
            digits_reg    <= digits_next;
            value_reg     <= value_next;
            six_reg       <= six_next;
            three_reg     <= three_next;
            chars_reg     <= chars_next;
            bad_reg       <= bad_next;
            wide_reg      <= wide_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg <= mac_next;
        ok_reg  <= ok_next;
        fmt_reg <= fmt_next;
    end

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> mac_reg == '0 && fmt_reg == FMT_INVALID)
        else $error("invalid result carries nonzero address or format");

    a_nul_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        take_nul |=> field_reg == '0 && digits_reg == '0 && chars_reg == '0 && !bad_reg)
        else $error("parser state not cleared after end of string");

    a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg <= MAX_DIGITS && field_reg <= LAST_FIELD_SIX && chars_reg <= MAX_LEN)
        else $error("parser counter out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !take_nul)
        else $error("result taken from queue while output is stalled");

endmodule

>>> rtl/core/mac_address_text_parser.sv
// Parses a MAC address written as text, one character per beat on text_char, with NUL ending
// the string. Six fields of 1-2 hex digits or three fields of 1-4 hex digits are accepted,
// split by one kind of separator (':', '-' or '.'); each NUL yields one result beat with the
// 48-bit address, valid_res and the format code (0-2 six fields, 3-5 three fields, in
// colon/dash/dot order), other characters yield none. The block takes one character per
// cycle while in_ready is high: a classifier feeds a QUEUE_DEPTH-entry queue that the parser
// drains one entry per cycle, except that a NUL waits while a result is still held, and
// out_valid rises at the edge where the parser takes the NUL from the queue. While a result
// waits in the output register, characters keep flowing until the parser reaches the next
// NUL; in_ready then drops once the queue is full.
module mac_address_text_parser
    import macp_pkg::*;
#(
    parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] mac_address,
    output logic        valid_res,
    output logic [2:0]  format
);

    char_entry_t classified;
    queue_head_t head;
    logic        full;
    logic        pop;

    assign in_ready = !full;

    macp_front u_front (
        .text_char (text_char),
        .entry     (classified)
    );

    macp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_entry (classified),
        .pop        (pop),
        .full       (full),
        .head       (head)
    );

    macp_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mac_address (mac_address),
        .valid_res   (valid_res),
        .format      (format)
    );

endmodule
